FILE: src/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg: shared types and constants for the Otsu threshold binarizer
// Request and result payload structs and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package otb_pkg;

  localparam int unsigned TotalBits = 25;
  localparam int unsigned PixBits   = 8;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned MeanBits  = 24;
  localparam int unsigned SumBits   = 32;

  typedef enum logic {
    MODE_BIN   = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_e;

  typedef struct packed {
    logic              mode;
    logic [24:0]       bin_count;
    logic [7:0]        pixel;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        threshold;
    logic [7:0]        pixel_out;
  } res_t;

endpackage

FILE: src/otb_divider.sv
// ----------------------------------------------------------------------------
// otb_divider: saturating unsigned Q8.16 mean divider
// Restoring divider, one quotient bit per cycle, num / den -> Q8.16.
// ----------------------------------------------------------------------------
module otb_divider #(
  parameter int unsigned NumBits = 42,
  parameter int unsigned DenBits = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NumBits-1:0]         num_i,
  input  logic [DenBits-1:0]         den_i,
  output logic                       done_o,
  output logic [otb_pkg::MeanBits-1:0] mean_o
);
  // Quotient bits above MeanBits-1 set the saturation flag; shift numerator left
  // by FracBits and produce quotient bits from QBits-1 down to 0.
  localparam int unsigned ShBits = NumBits + otb_pkg::FracBits;
  localparam int unsigned QBits  = ShBits;
  localparam int unsigned CntBits = $clog2(QBits + 1);

  logic [ShBits-1:0]  num_q, num_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic               sat_q, sat_d;
  logic [otb_pkg::MeanBits-1:0] quo_q, quo_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;
  logic [DenBits+1:0] diff;

  always_comb begin
    trial = {rem_q[DenBits-1:0], num_q[ShBits-1]};
    diff  = {1'b0, trial} - {2'b0, den_q};
    num_d = num_q; rem_d = rem_q; den_d = den_q; sat_d = sat_q;
    quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = {num_i, {otb_pkg::FracBits{1'b0}}};
      den_d = den_i; rem_d = '0; sat_d = 1'b0; quo_d = '0;
      cnt_d = CntBits'(QBits); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (!diff[DenBits+1]) begin
        rem_d = diff[DenBits:0];
        if (cnt_q > CntBits'(otb_pkg::MeanBits)) sat_d = 1'b1;
        quo_d = {quo_q[otb_pkg::MeanBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[otb_pkg::MeanBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    sat_q <= sat_d; quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign mean_o = sat_q ? {otb_pkg::MeanBits{1'b1}} : quo_q;
endmodule

FILE: src/otb_front.sv
// ----------------------------------------------------------------------------
// otb_front: request intake and classification
// Stores bins, accumulates the weighted level sum, queues pixels and sweep requests.
// ----------------------------------------------------------------------------
module otb_front #(
  parameter int unsigned NumBins   = 256,
  parameter int unsigned CountBits = 25,
  parameter int unsigned QDepth    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  otb_pkg::req_t                 req_i,
  output logic                          busy_o,
  // histogram memory read port for the back part
  input  logic [$clog2(NumBins)-1:0]    rd_addr_i,
  output logic [CountBits-1:0]          rd_data_o,
  // queue toward the back part
  output logic                          q_valid_o,
  output logic                          q_last_o,
  output logic [otb_pkg::PixBits-1:0]   q_pixel_o,
  output logic [otb_pkg::SumBits-1:0]   q_sum_o,
  input  logic                          q_pop_i
);
  localparam int unsigned IdxBits = $clog2(NumBins);
  localparam int unsigned PtrBits = $clog2(QDepth);

  typedef struct packed {
    logic                        last;
    logic [otb_pkg::PixBits-1:0] pixel;
    logic [otb_pkg::SumBits-1:0] sum;
  } ent_t;

  logic [CountBits-1:0] hist_mem [NumBins];
  logic [IdxBits-1:0]   idx_q, idx_d;
  logic [otb_pkg::SumBits-1:0] sum_q, sum_d;
  ent_t                 fifo_q [QDepth];
  logic [PtrBits-1:0]   wp_q, rp_q;
  logic [PtrBits:0]     cnt_q;
  logic                 pend_q;
  logic                 acc, push, is_bin, last;
  logic [CountBits-1:0] cnt_in;
  logic [otb_pkg::SumBits-1:0] sum_new;
  ent_t                 ent;

  // busy while the queue is full or a sweep is outstanding: the sweep reads
  // the histogram memory, and later requests need the new threshold
  assign busy_o = (cnt_q == (PtrBits+1)'(QDepth)) || pend_q;
  assign acc    = start_i && !busy_o;
  assign is_bin = (req_i.mode == otb_pkg::MODE_BIN);
  assign cnt_in = CountBits'(req_i.bin_count);
  assign last   = (idx_q == IdxBits'(NumBins - 1));
  assign sum_new = sum_q + otb_pkg::SumBits'(idx_q) * otb_pkg::SumBits'(cnt_in);
  assign push   = acc && (!is_bin || last);

  always_comb begin
    idx_d = idx_q; sum_d = sum_q;
    if (acc && is_bin) begin
      if (last) begin
        idx_d = '0; sum_d = '0;
      end else begin
        idx_d = idx_q + 1'b1; sum_d = sum_new;
      end
    end
    ent.last  = is_bin;
    ent.pixel = req_i.pixel;
    ent.sum   = sum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; sum_q <= '0; wp_q <= '0; rp_q <= '0; cnt_q <= '0;
      pend_q <= 1'b0;
    end else begin
      idx_q <= idx_d; sum_q <= sum_d;
      if (push) wp_q <= (wp_q == PtrBits'(QDepth-1)) ? '0 : wp_q + 1'b1;
      if (q_pop_i) rp_q <= (rp_q == PtrBits'(QDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(q_pop_i);
      if (push && is_bin) pend_q <= 1'b1;
      else if (q_pop_i && q_last_o) pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_bin) hist_mem[idx_q] <= cnt_in;
    rd_data_o <= hist_mem[rd_addr_i];
    if (push) fifo_q[wp_q] <= ent;
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_last_o  = fifo_q[rp_q].last;
  assign q_pixel_o = fifo_q[rp_q].pixel;
  assign q_sum_o   = fifo_q[rp_q].sum;
endmodule

FILE: src/otb_back.sv
// ----------------------------------------------------------------------------
// otb_back: threshold sweep and pixel binarization
// Sweeps the histogram with a shared mean divider and issues results.
// ----------------------------------------------------------------------------
module otb_back #(
  parameter int unsigned NumBins   = 256,
  parameter int unsigned CountBits = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [otb_pkg::TotalBits-1:0] total_i,
  output logic [$clog2(NumBins)-1:0]    rd_addr_o,
  input  logic [CountBits-1:0]          rd_data_i,
  input  logic                          q_valid_i,
  input  logic                          q_last_i,
  input  logic [otb_pkg::PixBits-1:0]   q_pixel_i,
  input  logic [otb_pkg::SumBits-1:0]   q_sum_i,
  output logic                          q_pop_o,
  output logic                          res_valid_o,
  output otb_pkg::res_t                 res_o
);
  localparam int unsigned IdxBits = $clog2(NumBins);
  localparam int unsigned WBits   = CountBits + IdxBits;
  localparam int unsigned SBits   = WBits + IdxBits;
  localparam int unsigned MB      = otb_pkg::MeanBits;
  localparam int unsigned WWBits  = 2 * WBits;
  localparam int unsigned VBits   = WWBits + 2 * MB;
  // variance product: one MB x MB chunk product per cycle
  localparam int unsigned PC      = MB;
  localparam int unsigned NWC     = (WWBits + PC - 1) / PC;
  localparam int unsigned PadBits = NWC * PC;
  localparam int unsigned WcBits  = $clog2(NWC + 1);
  localparam int unsigned TcBits  = IdxBits + CountBits;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ACC, S_DIVB, S_WAITB, S_DIVF, S_WAITF, S_MUL1, S_MUL2,
    S_CMP, S_NEXT, S_REPORT
  } state_e;

  state_e state_q;
  logic [IdxBits-1:0] t_q;
  logic [WBits-1:0]   wb_q, wf_q;
  logic [SBits-1:0]   sb_q, rest_q;
  logic [otb_pkg::SumBits-1:0] lsum_q;
  logic [MB-1:0]      mb_q, d_q;
  logic [WWBits-1:0]  ww_q;
  logic [2*MB-1:0]    dd_q;
  logic [VBits-1:0]   var_q, best_q;
  logic [IdxBits-1:0] level_q;
  logic               rv_q;
  otb_pkg::res_t      res_q;
  logic [WcBits-1:0]  wc_q;
  logic               dc_q;

  logic               div_start, div_done;
  logic [SBits-1:0]   div_num;
  logic [WBits-1:0]   div_den;
  logic [MB-1:0]      div_mean;
  logic [WBits-1:0]   wb_new;
  logic [SBits-1:0]   sb_new;
  logic [TcBits-1:0]  tc_prod;
  logic [WBits-1:0]   tot_w;
  logic [PadBits-1:0] ww_pad;
  logic [PC-1:0]      mw_part, md_part;
  logic [2*PC-1:0]    mpp;
  logic [VBits-1:0]   mpp_sh;
  logic               wc_last;

  assign tot_w   = WBits'(total_i);
  assign wb_new  = wb_q + WBits'(rd_data_i);
  assign tc_prod = TcBits'(t_q) * TcBits'(rd_data_i);
  assign sb_new  = sb_q + SBits'(tc_prod);
  assign div_start = (state_q == S_DIVB) || (state_q == S_DIVF);
  assign div_num   = (state_q == S_DIVB) ? sb_q : rest_q;
  assign div_den   = (state_q == S_DIVB) ? wb_q : wf_q;

  // chunk of wb*wf times chunk of d*d, shifted into place
  assign ww_pad  = PadBits'(ww_q);
  assign mw_part = ww_pad[wc_q*PC +: PC];
  assign md_part = dd_q[dc_q*PC +: PC];
  assign mpp     = mw_part * md_part;
  assign mpp_sh  = VBits'(mpp) << ((32'(wc_q) + 32'(dc_q)) * PC);
  assign wc_last = (wc_q == WcBits'(NWC - 1));

  otb_divider #(.NumBits(SBits), .DenBits(WBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .mean_o(div_mean)
  );

  assign rd_addr_o = t_q;
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i && !q_last_i
                   || (state_q == S_REPORT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; t_q <= '0; level_q <= '0; rv_q <= 1'b0;
      wb_q <= '0; wf_q <= '0; sb_q <= '0; rest_q <= '0; lsum_q <= '0;
      mb_q <= '0; d_q <= '0; ww_q <= '0; dd_q <= '0; var_q <= '0;
      best_q <= '0; res_q <= '0; wc_q <= '0; dc_q <= 1'b0;
    end else begin
      rv_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i && !q_last_i) begin
            rv_q <= 1'b1;
            res_q.kind      <= otb_pkg::MODE_PIXEL;
            res_q.threshold <= 8'(level_q);
            res_q.pixel_out <= (IdxBits'(q_pixel_i) > level_q
                                || (IdxBits < 8 && q_pixel_i > 8'(level_q)))
                               ? 8'hFF : 8'h00;
          end else if (q_valid_i) begin
            t_q <= '0; wb_q <= '0; sb_q <= '0; best_q <= '0; level_q <= '0;
            lsum_q <= q_sum_i;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_ACC;
        S_ACC: begin
          wb_q <= wb_new; sb_q <= sb_new;
          wf_q <= tot_w - wb_new;
          rest_q <= (SBits'(lsum_q) >= sb_new) ? SBits'(lsum_q) - sb_new : '0;
          if (wb_new == '0 || wb_new >= tot_w) state_q <= S_NEXT;
          else state_q <= S_DIVB;
        end
        S_DIVB: state_q <= S_WAITB;
        S_WAITB: if (div_done) begin
          mb_q <= div_mean; state_q <= S_DIVF;
        end
        S_DIVF: state_q <= S_WAITF;
        S_WAITF: if (div_done) begin
          d_q <= (mb_q > div_mean) ? mb_q - div_mean : div_mean - mb_q;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          ww_q <= wb_q * wf_q;
          dd_q <= d_q * d_q;
          var_q <= '0; wc_q <= '0; dc_q <= 1'b0;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          var_q <= var_q + mpp_sh;
          if (dc_q) begin
            dc_q <= 1'b0;
            if (wc_last) state_q <= S_CMP;
            else wc_q <= wc_q + 1'b1;
          end else begin
            dc_q <= 1'b1;
          end
        end
        S_CMP: begin
          if (var_q > best_q) begin
            best_q <= var_q; level_q <= t_q;
          end
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (t_q == IdxBits'(NumBins - 1)) state_q <= S_REPORT;
          else begin
            t_q <= t_q + 1'b1; state_q <= S_RD;
          end
        end
        S_REPORT: begin
          rv_q <= 1'b1;
          res_q.kind      <= otb_pkg::MODE_BIN;
          res_q.threshold <= 8'(level_q);
          res_q.pixel_out <= 8'h00;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;
endmodule

FILE: src/otsu_threshold_binarizer.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer: Otsu threshold over a streamed histogram
// Stores a grey-level histogram, picks the Otsu threshold, binarizes pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - Program total_pixels through cfg_we_i/cfg_wdata_i while idle.
//  - A request is taken at a clock edge with start high and busy low.
//    mode 0 requests carry bin counts in order 0..NUM_BINS-1, one per cycle
//    while busy is low; they are written straight into the histogram memory.
//  - After the last bin busy stays high while the back part sweeps every
//    level: one memory read, two serial mean divisions (57 quotient bits
//    each on the shared divider) and a six-step chunked variance multiply;
//    a level whose background weight is 0 or reaches the total is skipped.
//    Then one threshold result (kind 0), and requests are taken again.
//  - mode 1 requests are pixels; each yields one result (kind 1) via the
//    queue and the result register; when the back part is free, pixels
//    sustain one per cycle. A 4-entry queue sits between intake and back part.
//  - done_o pulses for one cycle with the result; the receiver cannot stall.
//  - Reset clears the threshold to 0, the bin index and the level sum; the
//    histogram memory is not cleared.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer #(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [otb_pkg::TotalBits-1:0] cfg_wdata_i,
  input  logic                          start,
  input  otb_pkg::req_t                 req_i,
  output logic                          busy,
  output logic                          done_o,
  output otb_pkg::res_t                 res_o
);
  localparam int unsigned IdxBits = $clog2(NUM_BINS);

  logic [otb_pkg::TotalBits-1:0] total_q;
  logic [IdxBits-1:0]            rd_addr;
  logic [COUNT_BITS-1:0]         rd_data;
  logic                          q_valid, q_last, q_pop;
  logic [otb_pkg::PixBits-1:0]   q_pixel;
  logic [otb_pkg::SumBits-1:0]   q_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) total_q <= '0;
    else if (cfg_we_i) total_q <= cfg_wdata_i;
  end

  otb_front #(.NumBins(NUM_BINS), .CountBits(COUNT_BITS)) u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .q_valid_o(q_valid), .q_last_o(q_last), .q_pixel_o(q_pixel),
    .q_sum_o(q_sum), .q_pop_i(q_pop)
  );

  otb_back #(.NumBins(NUM_BINS), .CountBits(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .total_i(total_q),
    .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .q_valid_i(q_valid), .q_last_i(q_last), .q_pixel_i(q_pixel),
    .q_sum_i(q_sum), .q_pop_o(q_pop),
    .res_valid_o(done_o), .res_o
  );
endmodule

FILE: sim/otsu_threshold_binarizer_tb.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_tb: self-checking bench for the Otsu binarizer
// Streams histograms and pixels with random gaps and predicts each threshold
// report and each binarized pixel. Every result strobe is checked in order.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBins  = 256;
  localparam int unsigned IdleLimit = 200000;
  localparam logic [63:0] MeanMax   = 64'hFF_FFFF;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [otb_pkg::TotalBits-1:0] cfg_wdata_i = '0;
  logic                          start = 1'b0;
  otb_pkg::req_t                 req_i = '0;
  logic                          busy;
  logic                          done_o;
  otb_pkg::res_t                 res_o;

  otsu_threshold_binarizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the block.
  logic [24:0] hist_mem [NumBins];
  int unsigned bin_pos;
  logic [31:0] level_sum;
  logic [7:0]  cur_level;
  logic [24:0] pixel_total;

  otb_pkg::res_t pending_res[$];
  int            fail_cnt = 0;
  int unsigned   idle_cycles = 0;

  // Truncating Q8.16 mean, saturated to 24 bits.
  function automatic logic [63:0] fixed_mean(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    q = num / den;
    r = num % den;
    if (q > (MeanMax >> otb_pkg::FracBits)) return MeanMax;
    m = (q << otb_pkg::FracBits) + ((r << otb_pkg::FracBits) / den);
    return (m > MeanMax) ? MeanMax : m;
  endfunction

  // Full sweep: first level with a strictly larger between-class variance.
  function automatic logic [7:0] otsu_level();
    logic [63:0]  wb;
    logic [63:0]  sb;
    logic [63:0]  wf;
    logic [63:0]  rest;
    logic [63:0]  mb;
    logic [63:0]  mf;
    logic [63:0]  d;
    logic [127:0] var_cur;
    logic [127:0] var_best;
    logic [7:0]   pick;
    wb = 0; sb = 0; var_best = 0; pick = 0;
    for (int t = 0; t < NumBins; t++) begin
      wb += 64'(hist_mem[t]);
      sb += 64'(t) * 64'(hist_mem[t]);
      if (wb == 0 || wb >= 64'(pixel_total)) continue;
      wf   = 64'(pixel_total) - wb;
      mb   = fixed_mean(sb, wb);
      rest = (64'(level_sum) >= sb) ? 64'(level_sum) - sb : 64'd0;
      mf   = fixed_mean(rest, wf);
      d    = (mb > mf) ? mb - mf : mf - mb;
      var_cur = 128'(wb * wf) * 128'(d * d);
      if (var_cur > var_best) begin
        var_best = var_cur;
        pick = t[7:0];
      end
    end
    return pick;
  endfunction

  // Update the shadow state for one accepted request and queue its result.
  task automatic predict_req(otb_pkg::req_t r);
    otb_pkg::res_t e;
    if (r.mode == otb_pkg::MODE_BIN) begin
      hist_mem[bin_pos] = r.bin_count;
      level_sum += 32'(bin_pos) * 32'(r.bin_count);
      bin_pos++;
      if (bin_pos < NumBins) return;
      cur_level = otsu_level();
      bin_pos = 0;
      level_sum = 0;
      e.kind = 1'b0;
      e.threshold = cur_level;
      e.pixel_out = 8'd0;
    end else begin
      e.kind = 1'b1;
      e.threshold = cur_level;
      e.pixel_out = (r.pixel > cur_level) ? 8'd255 : 8'd0;
    end
    pending_res.push_back(e);
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Issue one request; called and returning at a falling edge.
  task automatic send_req(otb_pkg::req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    // busy only moves at rising edges, so its value here holds at the next one
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_req(r);
    @(negedge clk_i);
  endtask

  function automatic otb_pkg::req_t bin_req(logic [24:0] cnt);
    otb_pkg::req_t r;
    r.mode = otb_pkg::MODE_BIN;
    r.bin_count = cnt;
    r.pixel = 8'($urandom());  // ignored field, toggled anyway
    return r;
  endfunction

  function automatic otb_pkg::req_t pix_req(logic [7:0] px);
    otb_pkg::req_t r;
    r.mode = otb_pkg::MODE_PIXEL;
    r.bin_count = 25'($urandom());
    r.pixel = px;
    return r;
  endfunction

  // Wait for the block to drain, then write total_pixels.
  task automatic write_total(logic [24:0] val);
    start <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pixel_total = val;
  endtask

  task automatic send_pixel_edges();
    send_req(pix_req(8'd0));
    send_req(pix_req(8'd255));
    send_req(pix_req(cur_level));
    send_req(pix_req(cur_level + 8'd1));
  endtask

  // Before any histogram the threshold is 0.
  task automatic test_pixels_after_reset();
    send_pixel_edges();
    send_req(pix_req(8'd1));
  endtask

  // Empty histogram with zero total: every level is skipped.
  task automatic test_empty_histogram();
    write_total(25'd0);
    for (int i = 0; i < NumBins; i++) send_req(bin_req(25'd0));
    send_pixel_edges();
  endtask

  // Two clear peaks: the threshold must fall between them.
  task automatic test_bimodal();
    write_total(25'd1000);
    for (int i = 0; i < NumBins; i++)
      send_req(bin_req((i == 50 || i == 200) ? 25'd500 : 25'd0));
    send_pixel_edges();
  endtask

  // Huge counts against a tiny total: sum wraps, foreground sum clamps,
  // means saturate, background reaching the total skips levels.
  task automatic test_extreme_counts();
    write_total(25'd2);
    for (int i = 0; i < NumBins; i++)
      send_req(bin_req((i == 0) ? 25'd1 : 25'h1FF_FFFF));
    send_pixel_edges();
    write_total(25'h1FF_FFFF);
    for (int i = 0; i < NumBins; i++) send_req(bin_req(25'h1FF_FFFF));
    send_pixel_edges();
  endtask

  // Random histograms with interleaved pixels.
  task automatic test_random_frames(int unsigned frames);
    logic [24:0] cnt;
    int unsigned sel;
    for (int f = 0; f < frames; f++) begin
      case ($urandom_range(0, 4))
        0: write_total(25'($urandom()));
        1: write_total(25'd16777216);
        default: write_total(25'($urandom_range(1000, 300000)));
      endcase
      for (int i = 0; i < NumBins; i++) begin
        if ($urandom_range(0, 9) < 3) send_req(pix_req(8'($urandom())));
        sel = $urandom_range(0, 9);
        if (sel < 2) cnt = 25'd0;
        else if (sel < 9) cnt = 25'($urandom_range(0, 2000));
        else cnt = 25'($urandom());
        send_req(bin_req(cnt));
      end
      for (int k = 0; k < 20; k++) send_req(pix_req(8'($urandom())));
    end
  endtask

  // Results cannot be held off; take each strobe as it comes.
  always @(posedge clk_i) begin
    otb_pkg::res_t e;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result kind=%0d threshold=%0d pixel_out=%0d",
               res_o.kind, res_o.threshold, res_o.pixel_out);
        fail_cnt++;
      end else begin
        e = pending_res.pop_front();
        if (res_o.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, res_o.kind);
          fail_cnt++;
        end
        if (res_o.threshold !== e.threshold) begin
          $error("threshold: expected %0d, got %0d", e.threshold, res_o.threshold);
          fail_cnt++;
        end
        if (res_o.pixel_out !== e.pixel_out) begin
          $error("pixel_out: expected %0d, got %0d", e.pixel_out, res_o.pixel_out);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without a request taken or a result seen.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    bin_pos = 0;
    level_sum = 0;
    cur_level = 0;
    pixel_total = 0;
    for (int i = 0; i < NumBins; i++) hist_mem[i] = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_pixels_after_reset();
    test_empty_histogram();
    test_bimodal();
    test_extreme_counts();
    test_random_frames(1);

    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: otsu_threshold_binarizer.f
src/otb_pkg.sv
src/otb_divider.sv
src/otb_front.sv
src/otb_back.sv
src/otsu_threshold_binarizer.sv
sim/otsu_threshold_binarizer_tb.sv
